// ===== hdl/quadratic_root_solver_core_assert.svh =====
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication under the block clock and reset
`define QRS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the block clock and reset
`define QRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

    localparam int COEF_W    = 32;
    localparam int ROOT_W    = 32;
    localparam int TOL_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int FRAC_W    = 16;
    localparam int RAD_W     = 64;
    localparam int SQ_STAGES = RAD_W / 2;
    localparam int DIV_N_W   = 34;
    localparam int DIV_Q_W   = DIV_N_W + FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 8'd1;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_LINEAR,
        KIND_ZEROC,
        KIND_ZEROB,
        KIND_REPEAT,
        KIND_TWO
    } kind_t;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_SINGLE = 2'd1,
        ST_NONE   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        kind_t                    kind;
        logic [RAD_W-1:0]         rad;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/qrs_front.sv =====
`default_nettype none

module qrs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [95:0]                   s_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [qrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [qrs_pkg::TOL_W-1:0]     cfg_data,
    output logic                               order_mode,
    input  wire logic                          fifo_full,
    output logic                               push,
    output qrs_pkg::item_t                     push_item
);
    import qrs_pkg::*;

    function automatic logic [COEF_W-1:0] mag32(input logic signed [COEF_W-1:0] v);
        logic [COEF_W-1:0] u;
        u = v;
        return v[COEF_W-1] ? (~u + 1'b1) : u;
    endfunction

    logic [TOL_W-1:0] tol_reg;
    logic             ord_reg;

    logic signed [COEF_W-1:0] in_a, in_b, in_c;
    logic                     fen;

    logic                     v1_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic                     a0_1_reg, b0_1_reg, c0_1_reg;

    logic                     v2_reg;
    logic signed [COEF_W-1:0] a2_reg, b2_reg, c2_reg;
    logic                     a0_2_reg, b0_2_reg, c0_2_reg;
    logic signed [63:0]       ac_reg;
    logic signed [63:0]       bb_reg;
    logic                     rlt_reg;

    logic [TOL_W-1:0]  tmin;
    logic [47:0]       ratio_lhs, ratio_rhs;
    logic signed [63:0] d4, neg_d4, lim;
    kind_t             kind;
    logic [RAD_W-1:0]  rad;

    assign cfg_ready  = 1'b1;
    assign order_mode = ord_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 16'd1;
            ord_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TOLERANCE) begin
                tol_reg <= cfg_data;
            end else if (cfg_index == REG_ORDER_MODE) begin
                ord_reg <= cfg_data[0];
            end
        end
    end

    assign in_a = s_tdata[31:0];
    assign in_b = s_tdata[63:32];
    assign in_c = s_tdata[95:64];

    // whole front stalls while the queue is full
    assign fen      = !fifo_full;
    assign s_tready = fen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (fen) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // floor(|c|*2^16/|a|) < max(tol,1) without a divide
    assign tmin      = (tol_reg == '0) ? 16'd1 : tol_reg;
    assign ratio_lhs = {mag32(c1_reg), 16'd0};
    assign ratio_rhs = 48'(mag32(a1_reg)) * 48'(tmin);

    always_ff @(posedge aclk) begin
        if (fen) begin
            a1_reg   <= in_a;
            b1_reg   <= in_b;
            c1_reg   <= in_c;
            a0_1_reg <= mag32(in_a) <= 32'(tol_reg);
            b0_1_reg <= mag32(in_b) <= 32'(tol_reg);
            c0_1_reg <= mag32(in_c) <= 32'(tol_reg);

            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            a0_2_reg <= a0_1_reg;
            b0_2_reg <= b0_1_reg;
            c0_2_reg <= c0_1_reg;
            ac_reg   <= 64'(a1_reg) * 64'(c1_reg);
            bb_reg   <= 64'(b1_reg) * 64'(b1_reg);
            rlt_reg  <= ratio_lhs < ratio_rhs;
        end
    end

    assign d4     = $signed({2'b00, bb_reg[63:2]}) - ac_reg;
    assign neg_d4 = -d4;
    assign lim    = $signed({34'd0, tol_reg, 14'd0});

    always_comb begin
        kind = KIND_NONE;
        rad  = '0;
        priority if (a0_2_reg && b0_2_reg) begin
            kind = KIND_NONE;
        end else if (a0_2_reg) begin
            kind = KIND_LINEAR;
        end else if (c0_2_reg) begin
            kind = KIND_ZEROC;
        end else if (b0_2_reg) begin
            if (ac_reg > 64'sd0) begin
                // negative radicand: clip to zero when -c/a is tiny
                kind = rlt_reg ? KIND_ZEROB : KIND_NONE;
            end else begin
                kind = KIND_ZEROB;
                rad  = -ac_reg;
            end
        end else if (d4 < 64'sd0) begin
            kind = (neg_d4 >= lim) ? KIND_NONE : KIND_REPEAT;
        end else if (d4 <= lim) begin
            kind = KIND_REPEAT;
        end else begin
            kind = KIND_TWO;
            rad  = d4;
        end
    end

    assign push           = v2_reg && fen;
    assign push_item.a    = a2_reg;
    assign push_item.b    = b2_reg;
    assign push_item.c    = c2_reg;
    assign push_item.kind = kind;
    assign push_item.rad  = rad;

endmodule

`default_nettype wire

// ===== hdl/qrs_fifo.sv =====
`default_nettype none

module qrs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  qrs_pkg::item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output qrs_pkg::item_t head_item
);
    import qrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign empty     = cnt_reg == '0;
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qrs_sqrt.sv =====
`default_nettype none

// Pipelined floor square root, two radicand bits per stage
module qrs_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [qrs_pkg::RAD_W-1:0]   rad,
    output logic [qrs_pkg::SQ_STAGES-1:0]    root
);
    import qrs_pkg::*;

    localparam int RW = SQ_STAGES + 2;

    logic [RW-1:0]        rem_reg  [SQ_STAGES];
    logic [SQ_STAGES-1:0] root_reg [SQ_STAGES];
    logic [RAD_W-1:0]     val_reg  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [RW-1:0]        rem_p;
        logic [SQ_STAGES-1:0] root_p;
        logic [RAD_W-1:0]     val_p;
        logic [RW+1:0]        t, trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign val_p  = rad;
        end else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign val_p  = val_reg[k-1];
        end

        assign t     = {rem_p, val_p[RAD_W-1:RAD_W-2]};
        assign trial = {2'b00, root_p, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? RW'(t - trial) : t[RW-1:0];
                root_reg[k] <= {root_p[SQ_STAGES-2:0], ge};
                val_reg[k]  <= {val_p[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/qrs_div.sv =====
`default_nettype none

// Pipelined restoring divider: quo = floor(num * 2^16 / den), one bit per stage
module qrs_div (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [qrs_pkg::DIV_N_W-1:0] num,
    input  wire logic [qrs_pkg::DIV_N_W-1:0] den,
    output logic [qrs_pkg::DIV_Q_W-1:0]      quo
);
    import qrs_pkg::*;

    logic [DIV_N_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0] dq_reg  [DIV_Q_W];
    logic [DIV_N_W-1:0] den_reg [DIV_Q_W];

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
        logic [DIV_N_W-1:0] rem_p, den_p;
        logic [DIV_Q_W-1:0] dq_p;
        logic [DIV_N_W:0]   t, dx;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_p = '0;
            assign dq_p  = {num, {FRAC_W{1'b0}}};
            assign den_p = den;
        end else begin : g_next
            assign rem_p = rem_reg[k-1];
            assign dq_p  = dq_reg[k-1];
            assign den_p = den_reg[k-1];
        end

        assign t  = {rem_p, dq_p[DIV_Q_W-1]};
        assign dx = {1'b0, den_p};
        assign ge = t >= dx;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? DIV_N_W'(t - dx) : t[DIV_N_W-1:0];
                dq_reg[k]  <= {dq_p[DIV_Q_W-2:0], ge};
                den_reg[k] <= den_p;
            end
        end
    end

    assign quo = dq_reg[DIV_Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/qrs_back.sv =====
`default_nettype none

module qrs_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           order_mode,
    input  wire logic           fifo_empty,
    input  qrs_pkg::item_t      head_item,
    output logic                fifo_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [63:0]         m_tdata,
    output logic [2:0]          m_tuser
);
    import qrs_pkg::*;

    localparam logic signed [51:0] ROOT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] ROOT_MIN = -52'sd2147483648;

    function automatic logic [DIV_N_W-1:0] mag36(input logic signed [35:0] v);
        logic [35:0] u;
        u = v[35] ? (~v + 1'b1) : v;
        return u[DIV_N_W-1:0];
    endfunction

    function automatic logic signed [ROOT_W-1:0] sat32(input logic signed [51:0] v);
        if (v > ROOT_MAX) begin
            return ROOT_MAX[ROOT_W-1:0];
        end else if (v < ROOT_MIN) begin
            return ROOT_MIN[ROOT_W-1:0];
        end
        return v[ROOT_W-1:0];
    endfunction

    logic adv;

    // sqrt-side payload
    logic                     va_reg    [SQ_STAGES];
    logic signed [COEF_W-1:0] pa_a_reg  [SQ_STAGES];
    logic signed [COEF_W-1:0] pa_b_reg  [SQ_STAGES];
    logic signed [COEF_W-1:0] pa_c_reg  [SQ_STAGES];
    kind_t                    pa_k_reg  [SQ_STAGES];

    // divider-side payload
    logic                     vb_reg    [DIV_Q_W];
    kind_t                    pb_k_reg  [DIV_Q_W];
    logic                     pb_bn_reg [DIV_Q_W];
    logic                     pb_sx_reg [DIV_Q_W];
    logic                     pb_sy_reg [DIV_Q_W];

    logic [SQ_STAGES-1:0] root;
    logic signed [35:0]   a36, b36, c36, s36, q2, nx, dx, ny, dy;
    logic [DIV_Q_W-1:0]   quo_x, quo_y;

    logic signed [51:0]       px, py, qx, qy, r1w, r2w;
    logic signed [ROOT_W-1:0] s1, s2, f1, f2;
    logic                     none, ovf;
    status_t                  st;
    kind_t                    fk;

    logic                     m_valid_reg;
    logic [ROOT_W-1:0]        r1_reg, r2_reg;
    status_t                  st_reg;
    logic                     ovf_reg;

    // advance all stages together when the output slot frees up
    assign adv      = !m_valid_reg || m_tready;
    assign fifo_pop = adv && !fifo_empty;

    qrs_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .rad  (head_item.rad),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '{default: 1'b0};
            vb_reg <= '{default: 1'b0};
        end else if (adv) begin
            va_reg[0] <= fifo_pop;
            for (int k = 1; k < SQ_STAGES; k++) begin
                va_reg[k] <= va_reg[k-1];
            end
            vb_reg[0] <= va_reg[SQ_STAGES-1];
            for (int k = 1; k < DIV_Q_W; k++) begin
                vb_reg[k] <= vb_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_a_reg[0] <= head_item.a;
            pa_b_reg[0] <= head_item.b;
            pa_c_reg[0] <= head_item.c;
            pa_k_reg[0] <= head_item.kind;
            for (int k = 1; k < SQ_STAGES; k++) begin
                pa_a_reg[k] <= pa_a_reg[k-1];
                pa_b_reg[k] <= pa_b_reg[k-1];
                pa_c_reg[k] <= pa_c_reg[k-1];
                pa_k_reg[k] <= pa_k_reg[k-1];
            end
            pb_k_reg[0]  <= pa_k_reg[SQ_STAGES-1];
            pb_bn_reg[0] <= b36[35];
            pb_sx_reg[0] <= nx[35] ^ dx[35];
            pb_sy_reg[0] <= ny[35] ^ dy[35];
            for (int k = 1; k < DIV_Q_W; k++) begin
                pb_k_reg[k]  <= pb_k_reg[k-1];
                pb_bn_reg[k] <= pb_bn_reg[k-1];
                pb_sx_reg[k] <= pb_sx_reg[k-1];
                pb_sy_reg[k] <= pb_sy_reg[k-1];
            end
        end
    end

    // pick divide operands once the square root is out
    assign a36 = 36'(pa_a_reg[SQ_STAGES-1]);
    assign b36 = 36'(pa_b_reg[SQ_STAGES-1]);
    assign c36 = 36'(pa_c_reg[SQ_STAGES-1]);
    assign s36 = $signed({3'b000, root, 1'b0});
    assign q2  = b36[35] ? (s36 - b36) : -(b36 + s36);

    always_comb begin
        nx = -b36;
        dx = a36;
        ny = c36 <<< 1;
        dy = q2;
        unique case (pa_k_reg[SQ_STAGES-1])
            KIND_LINEAR: begin
                nx = -c36;
                dx = b36;
            end
            KIND_ZEROB: begin
                nx = $signed({4'b0000, root});
            end
            KIND_REPEAT: begin
                dx = a36 <<< 1;
            end
            KIND_TWO: begin
                nx = q2;
                dx = a36 <<< 1;
            end
            default: begin
            end
        endcase
    end

    qrs_div u_div_x (
        .aclk (aclk),
        .en   (adv),
        .num  (mag36(nx)),
        .den  (mag36(dx)),
        .quo  (quo_x)
    );

    qrs_div u_div_y (
        .aclk (aclk),
        .en   (adv),
        .num  (mag36(ny)),
        .den  (mag36(dy)),
        .quo  (quo_y)
    );

    assign fk = pb_k_reg[DIV_Q_W-1];
    assign px = $signed({2'b00, quo_x});
    assign py = $signed({2'b00, quo_y});
    assign qx = pb_sx_reg[DIV_Q_W-1] ? -px : px;
    assign qy = pb_sy_reg[DIV_Q_W-1] ? -py : py;

    always_comb begin
        r1w  = qx;
        r2w  = qx;
        st   = ST_SINGLE;
        none = 1'b0;
        unique case (fk)
            KIND_LINEAR, KIND_REPEAT: begin
                st = ST_SINGLE;
            end
            KIND_ZEROC: begin
                st = ST_TWO;
                if (pb_bn_reg[DIV_Q_W-1]) begin
                    r2w = '0;
                end else begin
                    r1w = '0;
                end
            end
            KIND_ZEROB: begin
                st  = ST_TWO;
                r2w = -qx;
            end
            KIND_TWO: begin
                st = ST_TWO;
                if (pb_bn_reg[DIV_Q_W-1]) begin
                    r2w = qy;
                end else begin
                    r1w = qy;
                end
            end
            default: begin
                st   = ST_NONE;
                none = 1'b1;
            end
        endcase

        s1  = sat32(r1w);
        s2  = sat32(r2w);
        ovf = (r1w > ROOT_MAX) || (r1w < ROOT_MIN) || (r2w > ROOT_MAX) || (r2w < ROOT_MIN);
        f1  = s1;
        f2  = s2;
        if (order_mode) begin
            // nonnegative root first, two nonnegative roots ascending
            if (!s1[ROOT_W-1] && !s2[ROOT_W-1]) begin
                if (s1 > s2) begin
                    f1 = s2;
                    f2 = s1;
                end
            end else if (s1[ROOT_W-1]) begin
                f1 = s2;
                f2 = s1;
            end
        end
        if (none) begin
            f1  = '0;
            f2  = '0;
            ovf = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vb_reg[DIV_Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg  <= f1;
            r2_reg  <= f2;
            st_reg  <= st;
            ovf_reg <= ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {r2_reg, r1_reg};
    assign m_tuser  = {ovf_reg, st_reg};

endmodule

`default_nettype wire

// ===== hdl/quadratic_root_solver_core.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: coef_a, coef_b, coef_c
// m_*       out        m_tvalid / m_tready  tdata: roots; tuser: status, overflow
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Sustains one item per cycle while m_tready does not stall the back pipeline.
// Latency is set by two front stages, the queue, the 32-stage square root pipeline,
// the 50-stage dividers and the output register.
// aresetn is synchronous, active low; it clears all valid bits and the queue,
// and sets tolerance to 1 and order_mode to 0.
// A stall on m_tready freezes the back pipeline; the front keeps filling the
// queue until it is full, then drops s_tready.
`default_nettype none

module quadratic_root_solver_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [95:0]                   s_tdata,   // coef_a, coef_b, coef_c
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [63:0]                        m_tdata,   // root_first, root_second
    output logic [2:0]                         m_tuser,   // root_status[1:0], overflow
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [qrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [qrs_pkg::TOL_W-1:0]     cfg_data
);
    import qrs_pkg::*;

    logic  order_mode;
    logic  push, fifo_full, fifo_pop, fifo_empty;
    item_t push_item, head_item;

    qrs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .order_mode (order_mode),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_item  (push_item)
    );

    qrs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .empty     (fifo_empty),
        .head_item (head_item)
    );

    qrs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .order_mode (order_mode),
        .fifo_empty (fifo_empty),
        .head_item  (head_item),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/qrs_checker.sv =====
`default_nettype none

`include "quadratic_root_solver_core_assert.svh"

module qrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    import qrs_pkg::*;

    `QRS_ASSERT_IMPLY(a_none_zero, aclk, aresetn, m_tvalid && (m_tuser[1:0] == ST_NONE), m_tdata == 64'd0, "roots not zero with no root")
    `QRS_ASSERT_IMPLY(a_none_no_ovf, aclk, aresetn, m_tvalid && (m_tuser[1:0] == ST_NONE), !m_tuser[2], "overflow with no root")
    `QRS_ASSERT_IMPLY(a_single_equal, aclk, aresetn, m_tvalid && (m_tuser[1:0] == ST_SINGLE), m_tdata[31:0] == m_tdata[63:32], "repeated root differs")
    `QRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import qrs_pkg::*;

    typedef struct {
        logic [31:0] r1;
        logic [31:0] r2;
        logic [1:0]  st;
        logic        ov;
    } root_set_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TOL_W-1:0]     cfg_data = '0;

    logic [95:0]  coef_queue[$];
    root_set_t    root_queue[$];
    longint       eps_reg = 1;
    bit           ascending = 1'b0;
    bit           no_idle = 1'b0;
    bit           s_fire = 1'b0;
    int           mismatches = 0;
    longint       cycles = 0;

    quadratic_root_solver_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return longint'(r);
    endfunction

    function automatic longint q_div(longint num, longint den);
        return (num * 65536) / den;
    endfunction

    function automatic longint clamp32(longint v, ref bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic root_set_t solve_roots(logic [95:0] d);
        longint a, b, c, tol, r1, r2, t, p, ratio, d4, lim, s, q2;
        status_t st;
        bit ovf;
        root_set_t res;
        a = longint'($signed(d[31:0]));
        b = longint'($signed(d[63:32]));
        c = longint'($signed(d[95:64]));
        tol = eps_reg;
        r1 = 0;
        r2 = 0;
        st = ST_TWO;
        ovf = 1'b0;
        if ((a < 0 ? -a : a) <= tol && (b < 0 ? -b : b) <= tol) begin
            st = ST_NONE;
        end else if ((a < 0 ? -a : a) <= tol) begin
            r1 = q_div(-c, b);
            r2 = r1;
            st = ST_SINGLE;
        end else if ((c < 0 ? -c : c) <= tol) begin
            t = q_div(-b, a);
            if (b < 0) begin
                r1 = t;
            end else begin
                r2 = t;
            end
        end else if ((b < 0 ? -b : b) <= tol) begin
            p = -(a * c);
            if (p < 0) begin
                ratio = q_div(-c, a);
                // clip a slightly negative radicand to zero
                if (ratio == 0 || (ratio < 0 ? -ratio : ratio) < tol) p = 0;
                else st = ST_NONE;
            end
            if (st != ST_NONE) begin
                r1 = q_div(floor_sqrt(p), a);
                r2 = -r1;
            end
        end else begin
            // b*b is nonnegative and below 2^63
            d4 = ((b * b) >>> 2) - a * c;
            lim = tol * 16384;
            if (d4 < 0) begin
                if (-d4 >= lim) st = ST_NONE;
                else d4 = 0;
            end
            if (st != ST_NONE) begin
                if ((d4 < 0 ? -d4 : d4) <= lim) begin
                    r1 = q_div(-b, 2 * a);
                    r2 = r1;
                    st = ST_SINGLE;
                end else begin
                    s = 2 * floor_sqrt(d4);
                    q2 = (b < 0) ? -(b - s) : -(b + s);
                    if (b < 0) begin
                        r1 = q_div(q2, 2 * a);
                        r2 = q_div(2 * c, q2);
                    end else begin
                        r1 = q_div(2 * c, q2);
                        r2 = q_div(q2, 2 * a);
                    end
                end
            end
        end
        if (st != ST_NONE) begin
            r1 = clamp32(r1, ovf);
            r2 = clamp32(r2, ovf);
            if (ascending) begin
                if (r1 >= 0 && r2 >= 0) begin
                    if (r1 > r2) begin
                        t = r1; r1 = r2; r2 = t;
                    end
                end else if (r1 < 0) begin
                    t = r1; r1 = r2; r2 = t;
                end
            end
        end else begin
            r1 = 0;
            r2 = 0;
        end
        res.r1 = r1[31:0];
        res.r2 = r2[31:0];
        res.st = st;
        res.ov = ovf;
        return res;
    endfunction

    // Driver: change inputs at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_fire) begin
                // hold until transfer
            end else if (coef_queue.size() > 0 && (no_idle || $urandom_range(99) >= 20)) begin
                s_tdata <= coef_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    // Monitor: sample at the rising edge
    always @(posedge aclk) begin
        root_set_t want;
        cycles++;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            s_fire = aresetn && s_tvalid && s_tready;
            if (s_fire) root_queue.push_back(solve_roots(s_tdata));
            if (aresetn && cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TOLERANCE) eps_reg = longint'(cfg_data);
                else if (cfg_index == REG_ORDER_MODE) ascending = cfg_data[0];
            end
            if (aresetn && m_tvalid && m_tready) begin
                if (root_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h %h", m_tdata, m_tuser);
                end else begin
                    want = root_queue.pop_front();
                    if (m_tdata[31:0] !== want.r1 || m_tdata[63:32] !== want.r2
                            || m_tuser[1:0] !== want.st || m_tuser[2] !== want.ov) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp r1=%h r2=%h st=%0d ov=%b",
                                      " got r1=%h r2=%h st=%0d ov=%b"},
                                want.r1, want.r2, want.st, want.ov,
                                m_tdata[31:0], m_tdata[63:32], m_tuser[1:0], m_tuser[2]);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (coef_queue.size() > 0 || s_tvalid || root_queue.size() > 0);
    endtask

    function automatic logic [31:0] rand_coef(int unsigned tol);
        logic [31:0] v;
        case ($urandom_range(7))
            0, 1: v = $urandom;
            2:    v = $urandom_range(tol + 3);
            3:    v = -$urandom_range(tol + 3);
            4:    v = $signed($urandom_range(2097151)) - 1048576;
            5:    v = $signed($urandom_range(262143)) - 131072;
            6:    v = ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: v = $signed($urandom_range(33554431)) - 16777216;
        endcase
        return v;
    endfunction

    task automatic push_coef(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        coef_queue.push_back({c, b, a});
    endtask

    task automatic random_phase(int n, int unsigned tol);
        logic [31:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            a = rand_coef(tol);
            c = rand_coef(tol);
            b = rand_coef(tol);
            // one set in four on average gets a near-full-scale b, so that b dominates a*c
            if ($urandom_range(3) == 0) b = ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000001)
                                             - $urandom_range(65535);
            push_coef(a, b, c);
        end
    endtask

    initial begin
        int unsigned tols[6];
        bit          ords[6];
        tols = '{1, 0, 65535, 300, 16, 4096};
        ords = '{0, 1, 0, 1, 1, 0};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed at reset settings: tolerance 1, raw order
        push_coef(32'd0, 32'd1, 32'd5);                       // a and b near zero
        push_coef(32'd1, 32'd0, 32'h80000000);
        push_coef(32'd0, 32'h00020000, 32'h00030000);         // linear
        push_coef(32'd0, 32'd2, 32'h7FFFFFFF);                // linear saturates
        push_coef(32'h00010000, 32'hFFFD0000, 32'd0);         // zero c, b < 0
        push_coef(32'h00010000, 32'h00030000, 32'd1);         // zero c, b > 0
        push_coef(32'h00010000, 32'd0, 32'hFFFC0000);         // zero b, real
        push_coef(32'h00010000, 32'd1, 32'h00040000);         // zero b, no root
        push_coef(32'h7FFFFFFF, 32'd0, 32'd2);                // zero b, tiny ratio clips
        push_coef(32'h00010000, 32'hFFFE0000, 32'h00010000);  // repeated root
        push_coef(32'h00010000, 32'h00020000, 32'h00010001);  // slightly negative disc
        push_coef(32'h00010000, 32'h00010000, 32'h00100000);  // clearly negative disc
        push_coef(32'h00010000, 32'hFFFD0000, 32'h00020000);  // two roots, b < 0
        push_coef(32'h00010000, 32'h00030000, 32'h00020000);  // two roots, b > 0
        push_coef(32'd2, 32'h7FFFFFFF, 32'h80000000);         // saturation
        push_coef(32'h80000000, 32'h80000000, 32'h80000000);
        push_coef(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        push_coef(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        push_coef(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();

        write_reg(REG_ORDER_MODE, 16'd1);
        push_coef(32'h00010000, 32'hFFFD0000, 32'h00020000);  // both positive
        push_coef(32'h00010000, 32'h00010000, 32'hFFFA0000);  // mixed signs
        push_coef(32'h00010000, 32'h00050000, 32'h00060000);  // both negative
        drain();
        write_reg(8'd7, 16'hFFFF);                            // unmapped index

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TOLERANCE, TOL_W'(tols[ph]));
            write_reg(REG_ORDER_MODE, TOL_W'(ords[ph]));
            no_idle = (ph == 3);
            random_phase(300, tols[ph]);
            drain();
        end
        write_reg(REG_TOLERANCE, TOL_W'($urandom));
        write_reg(REG_ORDER_MODE, TOL_W'($urandom));
        random_phase(50, 32'(eps_reg));
        drain();

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && root_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
